[hw/rtl/elg_pkg.sv]
// ----------------------------------------------------------------------------
// elg_pkg
// Shared types and constants for the ElGamal decryption block.
// ----------------------------------------------------------------------------
package elg_pkg;

  localparam int MOD_BITS_DEF = 31;
  localparam int FIELD_W      = 31;

  // register indexes on the configuration port
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_SECRET  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED1,
    S_RED2,
    S_POW_SQ,
    S_POW_MUL,
    S_INV_CHK,
    S_INV_DIV,
    S_INV_MUL,
    S_INV_UPD,
    S_FIN_MUL,
    S_DONE
  } elg_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } elg_sts_t;

endpackage

[hw/rtl/elgamal_decrypt.sv]
// Throughput: one word at a time; the next word is taken once the current one
//   has moved to the output register.
// Reset: synchronous, active high; modulus returns to 97, exponent to 58.
// ----------------------------------------------------------------------------
// elgamal_decrypt
// ElGamal decryption: m = c2 * (c1^x)^-1 mod p with a shared serial
// multiplier and a serial divider for the extended Euclid loop.
// ----------------------------------------------------------------------------
module elgamal_decrypt #(
  parameter int MOD_BITS = elg_pkg::MOD_BITS_DEF,
  localparam int PD_W    = (MOD_BITS > 32) ? 64 : 32,
  localparam int ASH     = (MOD_BITS > 32) ? 3 : 2,
  localparam int ADDR_W  = ASH + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // cipher_first[30:0], cipher_second[61:31]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // plain_value[30:0]
  output logic              m_tuser,   // no_inverse[0]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [PD_W-1:0]   pwdata,
  output logic [PD_W-1:0]   prdata,
  output logic              pready
);
  import elg_pkg::*;

  localparam int W     = MOD_BITS;
  localparam int CNT_W = $clog2(MOD_BITS);

  elg_state_t state;
  elg_state_t state_next;

  logic [W-1:0] modulus;
  logic [W-1:0] secret_exponent;
  logic         reg_idx;

  logic         go;
  logic [W-1:0] c1_in;
  logic [W-1:0] c2_in;
  logic [W-1:0] base;
  logic [W-1:0] c2;
  logic [W-1:0] acc;
  logic [W-1:0] e_sh;
  logic [CNT_W-1:0] e_cnt;
  logic         e_last;
  logic [W-1:0] r0;
  logic [W-1:0] r1;
  logic [W-1:0] t0;
  logic [W-1:0] t1;
  logic [W-1:0] q;
  logic [W-1:0] qt;
  logic [W-1:0] t2;
  logic [W:0]   t_wrap;
  logic [W-1:0] res_plain;
  logic         res_err;

  logic         out_valid;
  logic [W-1:0] out_plain;
  logic         out_err;
  logic         out_load;

  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic [W-1:0] mul_res;
  elg_sts_t     mul_sts;
  logic         div_start;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  elg_sts_t     div_sts;

  logic [W+FIELD_W-1:0] c1_ext;
  logic [W+FIELD_W-1:0] c2_ext;
  logic [W+FIELD_W-1:0] plain_ext;
  logic [W+PD_W-1:0]    wdata_ext;
  logic [W+PD_W-1:0]    rdata_ext;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:ASH];
  assign wdata_ext = {{W{1'b0}}, pwdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= W'(97);
      secret_exponent <= W'(58);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MODULUS: modulus         <= wdata_ext[W-1:0];
        REG_SECRET:  secret_exponent <= wdata_ext[W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODULUS: rdata_ext = {{PD_W{1'b0}}, modulus};
      REG_SECRET:  rdata_ext = {{PD_W{1'b0}}, secret_exponent};
      default:     rdata_ext = '0;
    endcase
    prdata = rdata_ext[PD_W-1:0];
  end

  // ---------------------------------------------------------------- units
  elg_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus),
    .res   (mul_res),
    .sts   (mul_sts)
  );

  elg_divider #(.MOD_BITS(MOD_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (r0),
    .d     (r1),
    .quo   (div_quo),
    .rem   (div_rem),
    .sts   (div_sts)
  );

  assign c1_ext = {{W{1'b0}}, s_tdata[FIELD_W-1:0]};
  assign c2_ext = {{W{1'b0}}, s_tdata[2*FIELD_W-1:FIELD_W]};
  assign e_last = (e_cnt == CNT_W'(W - 1));
  assign out_load = (state == S_DONE) && (!out_valid || m_tready);

  // t0 - qt mod p
  always_comb begin
    t_wrap = {1'b0, t0} + {1'b0, modulus} - {1'b0, qt};
    t2     = (t0 >= qt) ? t0 - qt : t_wrap[W-1:0];
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (modulus < W'(2)) ? S_DONE : S_RED1;
        end
      end
      S_RED1:    if (mul_sts.done) state_next = S_RED2;
      S_RED2:    if (mul_sts.done) state_next = S_POW_SQ;
      S_POW_SQ: begin
        if (mul_sts.done) begin
          if (e_sh[W-1])   state_next = S_POW_MUL;
          else if (e_last) state_next = S_INV_CHK;
          else             state_next = S_POW_SQ;
        end
      end
      S_POW_MUL: begin
        if (mul_sts.done) state_next = e_last ? S_INV_CHK : S_POW_SQ;
      end
      S_INV_CHK: begin
        if (r1 != '0)          state_next = S_INV_DIV;
        else if (r0 == W'(1))  state_next = S_FIN_MUL;
        else                   state_next = S_DONE;
      end
      S_INV_DIV: if (div_sts.done) state_next = S_INV_MUL;
      S_INV_MUL: if (mul_sts.done) state_next = S_INV_UPD;
      S_INV_UPD: state_next = S_INV_CHK;
      S_FIN_MUL: if (mul_sts.done) state_next = S_DONE;
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_IDLE:    s_tready = 1'b1;
      S_RED1: begin
        mul_start = go;
        mul_a     = W'(1);
        mul_b     = c1_in;
      end
      S_RED2: begin
        mul_start = go;
        mul_a     = W'(1);
        mul_b     = c2_in;
      end
      S_POW_SQ: begin
        mul_start = go;
        mul_a     = acc;
        mul_b     = acc;
      end
      S_POW_MUL: begin
        mul_start = go;
        mul_a     = acc;
        mul_b     = base;
      end
      S_INV_DIV: div_start = go;
      S_INV_MUL: begin
        mul_start = go;
        mul_a     = t1;
        mul_b     = q;
      end
      S_FIN_MUL: begin
        mul_start = go;
        mul_a     = t0;
        mul_b     = c2;
      end
      S_INV_CHK, S_INV_UPD, S_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      // launch a unit on every state change and after every unit result
      go    <= (state_next != state) || mul_sts.done || div_sts.done;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        c1_in     <= c1_ext[W-1:0];
        c2_in     <= c2_ext[W-1:0];
        res_plain <= '0;
        res_err   <= 1'b1;
      end
      S_RED1: if (mul_sts.done) base <= mul_res;
      S_RED2: begin
        if (mul_sts.done) begin
          c2    <= mul_res;
          acc   <= W'(1);
          e_sh  <= secret_exponent;
          e_cnt <= '0;
        end
      end
      S_POW_SQ, S_POW_MUL: begin
        if (mul_sts.done) begin
          acc <= mul_res;
          // advance to the next exponent bit unless a multiply is still due
          if (state == S_POW_MUL || !e_sh[W-1]) begin
            e_sh  <= {e_sh[W-2:0], 1'b0};
            e_cnt <= e_cnt + 1'b1;
            r0    <= modulus;
            r1    <= mul_res;
            t0    <= '0;
            t1    <= W'(1);
          end
        end
      end
      S_INV_DIV: begin
        if (div_sts.done) begin
          q  <= div_quo;
          qt <= div_rem;
        end
      end
      S_INV_MUL: begin
        if (mul_sts.done) begin
          r0 <= r1;
          r1 <= qt;
          qt <= mul_res;
        end
      end
      S_INV_UPD: begin
        t0 <= t1;
        t1 <= t2;
      end
      S_FIN_MUL: begin
        if (mul_sts.done) begin
          res_plain <= mul_res;
          res_err   <= 1'b0;
        end
      end
      S_INV_CHK, S_DONE: ;
      default: ;
    endcase
  end

  // output register, parts the result from the next word's work
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_plain <= res_plain;
      out_err   <= res_err;
    end
  end

  assign plain_ext = {{FIELD_W{1'b0}}, out_plain};
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, plain_ext[FIELD_W-1:0]};
  assign m_tuser   = out_err;

  // ---------------------------------------------------------------- checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_plain == '0)
    else $error("error result carries a nonzero value");

  a_plain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_err |-> out_plain < modulus)
    else $error("result not reduced below the modulus");

  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && mul_sts.busy))
    else $error("multiplier launched while busy");

  a_coef_range: assert property (@(posedge clk) disable iff (rst)
    state == S_INV_CHK |-> t0 < modulus && t1 < modulus)
    else $error("Euclid coefficient out of range");

endmodule

[hw/rtl/elg_mulmod.sv]
// ----------------------------------------------------------------------------
// elg_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB
// first. Requires a < m; b may take any value.
// ----------------------------------------------------------------------------
module elg_mulmod #(
  parameter int MOD_BITS = elg_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MOD_BITS-1:0] a,
  input  logic [MOD_BITS-1:0] b,
  input  logic [MOD_BITS-1:0] m,
  output logic [MOD_BITS-1:0] res,
  output elg_pkg::elg_sts_t   sts
);
  import elg_pkg::*;

  localparam int CNT_W = $clog2(MOD_BITS);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] acc_next;
  logic [MOD_BITS-1:0] a_q;
  logic [MOD_BITS-1:0] b_sh;
  logic [MOD_BITS-1:0] m_q;
  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS:0]   dbl_red;
  logic [MOD_BITS:0]   sum;

  // double, reduce, then conditionally add a and reduce
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum     = dbl_red + {1'b0, a_q};
    if (b_sh[MOD_BITS-1]) begin
      acc_next = (sum >= {1'b0, m_q}) ? MOD_BITS'(sum - {1'b0, m_q}) : sum[MOD_BITS-1:0];
    end else begin
      acc_next = dbl_red[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MOD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc  <= '0;
      a_q  <= a;
      b_sh <= b;
      m_q  <= m;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= {b_sh[MOD_BITS-2:0], 1'b0};
    end
  end

  assign res      = acc;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

[hw/rtl/elg_divider.sv]
// ----------------------------------------------------------------------------
// elg_divider
// Restoring bit-serial divider: quotient and remainder of n / d, one
// quotient bit per cycle. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module elg_divider #(
  parameter int MOD_BITS = elg_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MOD_BITS-1:0] n,
  input  logic [MOD_BITS-1:0] d,
  output logic [MOD_BITS-1:0] quo,
  output logic [MOD_BITS-1:0] rem,
  output elg_pkg::elg_sts_t   sts
);
  import elg_pkg::*;

  localparam int CNT_W = $clog2(MOD_BITS);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [MOD_BITS-1:0] num_sh;
  logic [MOD_BITS-1:0] rem_q;
  logic [MOD_BITS-1:0] d_q;
  logic [MOD_BITS:0]   trial;
  logic                fits;

  always_comb begin
    trial = {rem_q, num_sh[MOD_BITS-1]};
    fits  = (trial >= {1'b0, d_q});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MOD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend bits
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      num_sh <= n;
      rem_q  <= '0;
      d_q    <= d;
    end else if (busy) begin
      num_sh <= {num_sh[MOD_BITS-2:0], fits};
      rem_q  <= fits ? MOD_BITS'(trial - {1'b0, d_q}) : trial[MOD_BITS-1:0];
    end
  end

  assign quo      = num_sh;
  assign rem      = rem_q;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule
